@@ sv/lea128_key_schedule_top_macros.svh @@
// Assertion macros used by the key schedule round engine.
`ifndef LEA128_KEY_SCHEDULE_TOP_MACROS_SVH
`define LEA128_KEY_SCHEDULE_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LEA128KS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define LEA128KS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/lea128ks_pkg.sv @@
// Types, constants and helpers for the LEA-128 key schedule.
package lea128ks_pkg;

    localparam int ROUND_COUNT = 24;
    localparam int ROUND_W     = 5;
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_COUNT - 1);

    // Queue geometry shared by the key and result queues
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Round constants
    localparam logic [31:0] DELTA [4] = '{
        32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
    };

    // Final rotate amount per state word
    localparam int WORD_ROT [4] = '{1, 3, 6, 11};

    typedef struct packed {
        logic [31:0] key_word0;
        logic [31:0] key_word1;
        logic [31:0] key_word2;
        logic [31:0] key_word3;
    } key_t;

    typedef struct packed {
        logic [ROUND_W-1:0] round_number;
        logic [31:0]        round_key0;
        logic [31:0]        round_key1;
        logic [31:0]        round_key2;
        logic [31:0]        round_key3;
        logic [31:0]        round_key4;
        logic [31:0]        round_key5;
        logic               is_final;
    } result_t;

    // Rotate left by a fixed amount; an amount of zero returns the word.
    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        logic [31:0] r;
        if (n == 0)
            r = v;
        else
            r = (v << n) | (v >> (32 - n));
        return r;
    endfunction

endpackage

@@ sv/lea128ks_key_queue.sv @@
// Front queue: accepts key requests and holds them for the round engine.
module lea128ks_key_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lea128ks_pkg::key_t  key,
    output logic                full,
    output logic                avail,
    output lea128ks_pkg::key_t  head,
    input  logic                take
);

    lea128ks_pkg::key_t                  mem [lea128ks_pkg::QUEUE_DEPTH];
    logic [lea128ks_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lea128ks_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lea128ks_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                                do_push, do_take;

    // Status
    assign full    = (count_reg == lea128ks_pkg::QCNT_W'(lea128ks_pkg::QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_take = take && avail;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_take)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_take)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= key;
    end

endmodule

@@ sv/lea128ks_round_engine.sv @@
// Back end: expands a key into round keys, one round per cycle unless out_full.
`include "lea128_key_schedule_top_macros.svh"

module lea128ks_round_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_avail,
    input  lea128ks_pkg::key_t     key_head,
    output logic                   key_take,
    input  logic                   out_full,
    output logic                   out_push,
    output lea128ks_pkg::result_t  out_data
);

    logic                                busy_reg, busy_next;
    logic [lea128ks_pkg::ROUND_W-1:0]    round_reg, round_next;
    logic [31:0]                         t_reg [4];
    logic [31:0]                         drot_reg [4];
    logic [31:0]                         t_new [4];
    logic [31:0]                         dsel;
    logic                                adv, last, load;

    // Handshake with both queues
    assign adv      = busy_reg && !out_full;
    assign last     = (round_reg == lea128ks_pkg::LAST_ROUND);
    assign load     = key_avail && (!busy_reg || (adv && last));
    assign key_take = load;
    assign out_push = adv;

    // One round: add rotated delta, then fixed rotate per word
    always_comb
    begin
        dsel = drot_reg[round_reg[1:0]];
        for (int j = 0; j < 4; j++)
            t_new[j] = lea128ks_pkg::rotl(t_reg[j] + lea128ks_pkg::rotl(dsel, j),
                                          lea128ks_pkg::WORD_ROT[j]);
    end

    // Result word order: T0, T1, T2, T1, T3, T1
    always_comb
    begin
        out_data.round_number = round_reg;
        out_data.round_key0   = t_new[0];
        out_data.round_key1   = t_new[1];
        out_data.round_key2   = t_new[2];
        out_data.round_key3   = t_new[1];
        out_data.round_key4   = t_new[3];
        out_data.round_key5   = t_new[1];
        out_data.is_final     = last;
    end

    // Control next state
    always_comb
    begin
        busy_next  = busy_reg;
        round_next = round_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            round_next = '0;
        end
        else if (adv)
        begin
            if (last)
                busy_next = 1'b0;
            round_next = round_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
        end
    end

    // Working state and per-round delta rotations (delta[k] rotated by round)
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t_reg[0] <= key_head.key_word0;
            t_reg[1] <= key_head.key_word1;
            t_reg[2] <= key_head.key_word2;
            t_reg[3] <= key_head.key_word3;
            for (int k = 0; k < 4; k++)
                drot_reg[k] <= lea128ks_pkg::DELTA[k];
        end
        else if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                t_reg[k]    <= t_new[k];
                drot_reg[k] <= lea128ks_pkg::rotl(drot_reg[k], 1);
            end
        end
    end

    // Checks
    `LEA128KS_NEVER(a_round_range, busy_reg && (round_reg > lea128ks_pkg::LAST_ROUND),
        "round counter beyond last round")
    `LEA128KS_ASSERT(a_load_starts, load |=> (busy_reg && round_reg == '0),
        "key load did not start at round zero")
    `LEA128KS_ASSERT(a_last_idles, (adv && last && !load) |=> !busy_reg,
        "engine stayed busy after final round")
    `LEA128KS_NEVER(a_load_while_mid, load && busy_reg && !(adv && last),
        "new key taken in the middle of an expansion")

endmodule

@@ sv/lea128ks_out_queue.sv @@
// Result queue: decouples the round engine from the consumer.
module lea128ks_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lea128ks_pkg::result_t  data_in,
    output logic                   full,
    output logic                   empty,
    output lea128ks_pkg::result_t  data_out,
    input  logic                   pop
);

    lea128ks_pkg::result_t               mem [lea128ks_pkg::QUEUE_DEPTH];
    logic [lea128ks_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lea128ks_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lea128ks_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                                do_push, do_pop;

    // Status
    assign full     = (count_reg == lea128ks_pkg::QCNT_W'(lea128ks_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign data_out = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= data_in;
    end

endmodule

@@ sv/lea128_key_schedule_top.sv @@
// LEA-128 key schedule: 24 round keys per accepted key request.
// An accepted key waits in the key queue and is loaded into the round engine; its round
// keys reach the result ports through the result queue, one round key per cycle while
// the consumer pops. All keys use the single round datapath (one add and
// rotate per word per cycle); a queued key loads in the cycle of the previous final round.
// Reset: asynchronous, clears both queues and idles the round engine; no clearing pass.
module lea128_key_schedule_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lea128ks_pkg::key_t     key,
    output logic                   full,
    output logic                   empty,
    input  logic                   pop,
    output lea128ks_pkg::result_t  result
);

    logic                   key_avail;
    logic                   key_take;
    lea128ks_pkg::key_t     key_head;
    logic                   out_full;
    logic                   out_push;
    lea128ks_pkg::result_t  out_data;

    // Front: key request queue
    lea128ks_key_queue u_key_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .key   (key),
        .full  (full),
        .avail (key_avail),
        .head  (key_head),
        .take  (key_take)
    );

    // Back: round engine
    lea128ks_round_engine u_round_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_avail (key_avail),
        .key_head  (key_head),
        .key_take  (key_take),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_data)
    );

    // Result queue
    lea128ks_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .data_in  (out_data),
        .full     (out_full),
        .empty    (empty),
        .data_out (result),
        .pop      (pop)
    );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the LEA-128 key schedule: directed and random keys, predicted round keys.
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_KEYS  = 400;
    localparam int IDLE_PCT     = 29;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 50;
    // Window of cycles with no idling on either side
    localparam int STEADY_FROM  = 1500;
    localparam int STEADY_TO    = 4500;

    // Round constants and per-word rotate amounts of LEA-128
    localparam logic [31:0] LEA_DELTA [4] = '{
        32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
    };
    localparam int unsigned WORD_SHIFT [4] = '{1, 3, 6, 11};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    lea128ks_pkg::key_t     key = '0;
    logic                   full;
    logic                   empty;
    logic                   pop = 1'b0;
    lea128ks_pkg::result_t  result;

    lea128ks_pkg::key_t     pending_keys [$];
    lea128ks_pkg::result_t  round_keys_due [$];
    lea128ks_pkg::result_t  want_rk;

    logic    key_accepted = 1'b0;
    int      cycle_no = 0;
    int      stall_cycles = 0;
    int      keys_taken = 0;
    int      round_keys_seen = 0;
    int      error_count = 0;

    lea128_key_schedule_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .key    (key),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // True rotate-left, amount taken mod 32
    function automatic logic [31:0] rotl_word(logic [31:0] v, int unsigned n);
        int unsigned s;
        s = n % 32;
        if (s == 0)
            return v;
        return (v << s) | (v >> (32 - s));
    endfunction

    // Expand one key into its 24 round keys and queue them as expected results
    function automatic void expand_key(lea128ks_pkg::key_t k);
        logic [31:0]            t [4];
        lea128ks_pkg::result_t  rk;
        t[0] = k.key_word0;
        t[1] = k.key_word1;
        t[2] = k.key_word2;
        t[3] = k.key_word3;
        for (int unsigned i = 0; i < 24; i++)
        begin
            for (int unsigned j = 0; j < 4; j++)
                t[j] = rotl_word(t[j] + rotl_word(LEA_DELTA[i % 4], i + j), WORD_SHIFT[j]);
            rk.round_number = 5'(i);
            rk.round_key0   = t[0];
            rk.round_key1   = t[1];
            rk.round_key2   = t[2];
            rk.round_key3   = t[1];
            rk.round_key4   = t[3];
            rk.round_key5   = t[1];
            rk.is_final     = (i == 23);
            round_keys_due.push_back(rk);
        end
    endfunction

    // Random key word, biased toward extremes and single bits
    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_word(string field, int unsigned rnd, logic [31:0] got,
                                logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("round %0d %s: got %h, want %h", rnd, field, got,
                                      exp_val));
    endtask

    function automatic bit steady_window();
        return cycle_no >= STEADY_FROM && cycle_no < STEADY_TO;
    endfunction

    function automatic bit take_break();
        return !steady_window() && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Request driver: holds a key until it is taken, may idle between keys
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || key_accepted)
            begin
                if (pending_keys.size() != 0 && !take_break())
                begin
                    key  <= pending_keys.pop_front();
                    push <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
            pop <= !take_break();
        end
    end

    // Monitor: predict on accepted keys, check each popped round key
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_no     <= cycle_no + 1;
            key_accepted <= push && !full;
            if (push && !full)
            begin
                expand_key(key);
                keys_taken++;
            end
            if (pop && !empty)
            begin
                round_keys_seen++;
                if (round_keys_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected round key, round %0d",
                                              result.round_number));
                end
                else
                begin
                    want_rk = round_keys_due.pop_front();
                    compare_word("round_number", want_rk.round_number,
                                 32'(result.round_number), 32'(want_rk.round_number));
                    compare_word("round_key0", want_rk.round_number, result.round_key0,
                                 want_rk.round_key0);
                    compare_word("round_key1", want_rk.round_number, result.round_key1,
                                 want_rk.round_key1);
                    compare_word("round_key2", want_rk.round_number, result.round_key2,
                                 want_rk.round_key2);
                    compare_word("round_key3", want_rk.round_number, result.round_key3,
                                 want_rk.round_key3);
                    compare_word("round_key4", want_rk.round_number, result.round_key4,
                                 want_rk.round_key4);
                    compare_word("round_key5", want_rk.round_number, result.round_key5,
                                 want_rk.round_key5);
                    compare_word("is_final", want_rk.round_number, 32'(result.is_final),
                                 32'(want_rk.is_final));
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        // directed: extremes, alternating patterns, single bits
        pending_keys.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
        pending_keys.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        pending_keys.push_back('{32'hffffffff, 32'h0, 32'h0, 32'h0});
        pending_keys.push_back('{32'h0, 32'hffffffff, 32'h0, 32'h0});
        pending_keys.push_back('{32'h0, 32'h0, 32'hffffffff, 32'h0});
        pending_keys.push_back('{32'h0, 32'h0, 32'h0, 32'hffffffff});
        pending_keys.push_back('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555});
        pending_keys.push_back('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa});
        pending_keys.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        pending_keys.push_back('{32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001});
        pending_keys.push_back('{32'h7fffffff, 32'hfffffffe, 32'h7fffffff, 32'hfffffffe});
        pending_keys.push_back('{32'h3c2d1e0f, 32'h78695a4b, 32'hb4a59687, 32'hf0e1d2c3});
        // first-round sums come out zero, so the final rotates act on zero
        pending_keys.push_back('{32'h0 - rotl_word(LEA_DELTA[0], 0),
                                 32'h0 - rotl_word(LEA_DELTA[0], 1),
                                 32'h0 - rotl_word(LEA_DELTA[0], 2),
                                 32'h0 - rotl_word(LEA_DELTA[0], 3)});
        // first-round sums all ones, with no carry out of any bit
        pending_keys.push_back('{32'hffffffff - rotl_word(LEA_DELTA[0], 0),
                                 32'hffffffff - rotl_word(LEA_DELTA[0], 1),
                                 32'hffffffff - rotl_word(LEA_DELTA[0], 2),
                                 32'hffffffff - rotl_word(LEA_DELTA[0], 3)});

        // random keys
        for (int n = 0; n < RANDOM_KEYS; n++)
            pending_keys.push_back('{pick_word(), pick_word(), pick_word(), pick_word()});

        // reset
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // wait for every key to be taken and every round key to come back
        @(negedge clk);
        while (pending_keys.size() != 0 || push || round_keys_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (round_keys_due.size() != 0)
            report_mismatch($sformatf("%0d round keys never arrived", round_keys_due.size()));

        $display("Expanded %0d keys (directed extremes plus random), checked %0d round keys,",
                 keys_taken, round_keys_seen);
        $display("with random idling on both sides and one stretch at full rate; %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
